// File: hdl/tbm_pkg.sv
// shared constants and codes for the ternary bitmap matrix-vector unit
// no dependencies; used by the channel interfaces and the top level
package tbm_pkg;

  localparam int LANES     = 8;
  localparam int ACT_W     = 8;
  localparam int SUM_W     = 21;
  localparam int IDX_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int BLK_SUM_W = 12;

  localparam int DEF_MAX_COLS = 4096;
  localparam int DEF_MAX_ROWS = 4096;

  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b1;

  // item modes
  localparam logic MODE_ACT    = 1'b0;
  localparam logic MODE_WEIGHT = 1'b1;

endpackage

// File: hdl/tbm_in_if.sv
// input channel: activation writes and weight blocks
// depends on tbm_pkg
interface tbm_in_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [tbm_pkg::IDX_W-1:0]       act_index;
  logic signed [tbm_pkg::ACT_W-1:0] act_value;
  logic [tbm_pkg::LANES-1:0]       zero_mask;
  logic [tbm_pkg::LANES-1:0]       minus_mask;

  modport source (
    output valid, mode, act_index, act_value, zero_mask, minus_mask,
    input  ready
  );
  modport sink (
    input  valid, mode, act_index, act_value, zero_mask, minus_mask,
    output ready
  );
endinterface

// File: hdl/tbm_out_if.sv
// output channel: finished row sums
// depends on tbm_pkg
interface tbm_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [tbm_pkg::SUM_W-1:0] row_sum;
  logic [tbm_pkg::IDX_W-1:0]        row_index;
  logic                             last_row;

  modport source (
    output valid, row_sum, row_index, last_row,
    input  ready
  );
  modport sink (
    input  valid, row_sum, row_index, last_row,
    output ready
  );
endinterface

// File: hdl/ternary_bitmap_matvec_unit.sv
// ternary-weight matrix times int8 vector, one 8-column weight block per transfer
// depends on tbm_pkg, tbm_in_if and tbm_out_if
//
// Usage: in_ch carries two kinds of item. mode 0 writes one signed activation
// at act_index and restarts the product (row, block and sum cleared). mode 1
// carries one weight block of the current row as zero and minus bitmaps; lanes
// past col_count weigh zero. After the last block of a row, out_ch gives the
// row sum, the row index and a flag for the final row; then the next row
// starts, and after the final row the row index wraps to 0.
// Activations live in a memory of MAX_COLS/8 words of eight bytes, so one
// block reads all its eight activations in a single access.
// Timing: one item per cycle sustained while out_ch keeps up. A result is offered
// on out_ch after its last block transfers (memory read at the transfer edge, then
// add into the output register).
// in_ch.ready drops only while the output register holds a result that out_ch
// has not taken; the pipeline then holds as a whole.
// Reset clears the pipeline, the counters, the sum and sets both registers to
// 4096; activation memory contents are undefined until written.
// The user must write configuration (cfg_write, cfg_index, cfg_data) only while idle; the block does not enforce this.
module ternary_bitmap_matvec_unit #(
  parameter int MAX_COLS = tbm_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = tbm_pkg::DEF_MAX_ROWS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [tbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tbm_pkg::CFG_W-1:0]         cfg_data,
  tbm_in_if.sink                            in_ch,
  tbm_out_if.source                         out_ch
);

  localparam int BLK_DEPTH = (MAX_COLS + tbm_pkg::LANES - 1) / tbm_pkg::LANES;
  localparam int AW        = (BLK_DEPTH > 1) ? $clog2(BLK_DEPTH) : 1;
  localparam int RW        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW        = $clog2(MAX_COLS + 1);
  localparam int DW        = CW + 1;
  localparam int RCW       = $clog2(MAX_ROWS + 1) + 1;
  localparam int WORD_W    = tbm_pkg::LANES * tbm_pkg::ACT_W;

  // configuration registers
  logic [tbm_pkg::CFG_W-1:0] col_count;
  logic [tbm_pkg::CFG_W-1:0] row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= tbm_pkg::CFG_RESET;
      row_count <= tbm_pkg::CFG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tbm_pkg::CFG_COL_COUNT: col_count <= cfg_data;
        tbm_pkg::CFG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // activation memory, eight bytes per word
  logic [WORD_W-1:0] act_mem [0:BLK_DEPTH-1];

  // front counters
  logic [AW-1:0] block_counter;
  logic [RW-1:0] row_counter;

  // pipeline stage after the memory read
  logic                           s1_valid;
  logic                           s1_mode;
  logic [tbm_pkg::LANES-1:0]      s1_plus;
  logic [tbm_pkg::LANES-1:0]      s1_neg;
  logic                           s1_last_blk;
  logic [tbm_pkg::IDX_W-1:0]      s1_row_index;
  logic                           s1_last_row;
  logic [WORD_W-1:0]              rd_word;

  logic signed [tbm_pkg::SUM_W-1:0] acc;

  // output register
  logic                             out_valid;
  logic signed [tbm_pkg::SUM_W-1:0] out_sum;
  logic [tbm_pkg::IDX_W-1:0]        out_index;
  logic                             out_last;

  logic advance;
  logic accept;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;

  // block geometry for the current row position
  logic [CW-1:0]              cols;
  logic [RCW-1:0]             rows;
  logic [DW-1:0]              blocks;
  logic [DW-1:0]              base;
  logic [DW-1:0]              rem;
  logic [tbm_pkg::LANES-1:0]  lane_mask;
  logic                       last_blk;
  logic                       last_row;

  always_comb begin
    if (col_count == '0) begin
      cols = CW'(1);
    end else if (col_count > MAX_COLS) begin
      cols = CW'(MAX_COLS);
    end else begin
      cols = CW'(col_count);
    end
    if (row_count == '0) begin
      rows = RCW'(1);
    end else if (row_count > MAX_ROWS) begin
      rows = RCW'(MAX_ROWS);
    end else begin
      rows = RCW'(row_count);
    end
    blocks   = (DW'(cols) + DW'(tbm_pkg::LANES - 1)) >> 3;
    base     = DW'(block_counter) << 3;
    rem      = (base < DW'(cols)) ? (DW'(cols) - base) : '0;
    for (int i = 0; i < tbm_pkg::LANES; i++) begin
      lane_mask[i] = (rem > DW'(i));
    end
    last_blk = (DW'(block_counter) + DW'(1)) >= blocks;
    last_row = (RCW'(row_counter) + RCW'(1)) >= rows;
  end

  // memory write and read, both at the transfer edge
  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_ch.mode == tbm_pkg::MODE_ACT) begin
        if ({20'd0, in_ch.act_index} < MAX_COLS) begin
          act_mem[AW'(in_ch.act_index[tbm_pkg::IDX_W-1:3])]
                 [{in_ch.act_index[2:0], 3'b000} +: tbm_pkg::ACT_W] <= in_ch.act_value;
        end
      end else begin
        rd_word <= act_mem[block_counter];
      end
    end
  end

  // counters advance at the transfer so the next block sees them at once
  always_ff @(posedge clk) begin
    if (rst) begin
      block_counter <= '0;
      row_counter   <= '0;
    end else if (accept) begin
      if (in_ch.mode == tbm_pkg::MODE_ACT) begin
        block_counter <= '0;
        row_counter   <= '0;
      end else if (last_blk) begin
        block_counter <= '0;
        row_counter   <= last_row ? '0 : row_counter + RW'(1);
      end else begin
        block_counter <= block_counter + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode      <= in_ch.mode;
      s1_plus      <= ~in_ch.zero_mask & ~in_ch.minus_mask & lane_mask;
      s1_neg       <= ~in_ch.zero_mask & in_ch.minus_mask & lane_mask;
      s1_last_blk  <= last_blk;
      s1_row_index <= tbm_pkg::IDX_W'(row_counter);
      s1_last_row  <= last_row;
    end
  end

  // sign-selected sum of the eight lanes
  logic signed [tbm_pkg::BLK_SUM_W-1:0] blk_sum;
  logic signed [tbm_pkg::SUM_W-1:0]     acc_next;

  always_comb begin
    logic signed [tbm_pkg::BLK_SUM_W-1:0] term;
    blk_sum = '0;
    for (int i = 0; i < tbm_pkg::LANES; i++) begin
      term = tbm_pkg::BLK_SUM_W'(signed'(rd_word[i*tbm_pkg::ACT_W +: tbm_pkg::ACT_W]));
      if (s1_plus[i]) begin
        blk_sum = blk_sum + term;
      end else if (s1_neg[i]) begin
        blk_sum = blk_sum - term;
      end
    end
    acc_next = acc + tbm_pkg::SUM_W'(blk_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid && (s1_mode == tbm_pkg::MODE_WEIGHT) && s1_last_blk;
      if (s1_valid) begin
        if (s1_mode == tbm_pkg::MODE_ACT || s1_last_blk) begin
          acc <= '0;
        end else begin
          acc <= acc_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && (s1_mode == tbm_pkg::MODE_WEIGHT) && s1_last_blk) begin
      out_sum   <= acc_next;
      out_index <= s1_row_index;
      out_last  <= s1_last_row;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.row_sum   = out_sum;
  assign out_ch.row_index = out_index;
  assign out_ch.last_row  = out_last;

endmodule
